// File: src/m3i_pkg.sv
// m3i_pkg: shared types and constants for the 3x3 matrix inverse core
// no dependencies; used by every module of the core
`timescale 1ns / 1ps

package m3i_pkg;

    // elements in one 3x3 matrix
    localparam int NUM_ELEMS = 9;

    // per-element flags leaving a divider lane
    typedef struct packed {
        logic big;   // quotient magnitude at or above 2^WORD_BITS
        logic neg;   // result sign
    } div_flags_t;

endpackage

// File: src/m3i_cofactor.sv
// m3i_cofactor: two-stage cofactor unit (products, then differences)
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_cofactor #(
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] a     [m3i_pkg::NUM_ELEMS],
    output logic signed [2*W:0] cof   [m3i_pkg::NUM_ELEMS],
    output logic signed [W-1:0] a_row [3]
);

    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;

    logic signed [PW-1:0] p_reg    [m3i_pkg::NUM_ELEMS];
    logic signed [PW-1:0] s_reg    [m3i_pkg::NUM_ELEMS];
    logic signed [CW-1:0] cof_reg  [m3i_pkg::NUM_ELEMS];
    logic signed [W-1:0]  row1_reg [3];
    logic signed [W-1:0]  row2_reg [3];

    // stage 1: the two minor products, stage 2: their difference
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p_reg[i*3+j] <= a[((i+1)%3)*3 + (j+1)%3] * a[((i+2)%3)*3 + (j+2)%3];
                    s_reg[i*3+j] <= a[((i+1)%3)*3 + (j+2)%3] * a[((i+2)%3)*3 + (j+1)%3];
                end
            end
            for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++) begin
                cof_reg[k] <= CW'(p_reg[k]) - CW'(s_reg[k]);
            end
            for (int j = 0; j < 3; j++) begin
                row1_reg[j] <= a[j];
                row2_reg[j] <= row1_reg[j];
            end
        end
    end

    assign cof   = cof_reg;
    assign a_row = row2_reg;

endmodule

// File: src/m3i_det.sv
// m3i_det: three-stage determinant unit (split products, terms, sum)
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_det #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [W-1:0]   a_row [3],
    input  logic signed [2*W:0]   cof   [m3i_pkg::NUM_ELEMS],
    output logic signed [3*W+1:0] det,
    output logic signed [2*W:0]   cof_d [m3i_pkg::NUM_ELEMS]
);

    localparam int CW   = 2 * W + 1;
    localparam int HW   = 2 * W + 1;
    localparam int TW   = 3 * W + 1;
    localparam int DETW = 3 * W + 2;

    logic signed [HW-1:0]   pl_reg [3];
    logic signed [HW-1:0]   ph_reg [3];
    logic signed [TW-1:0]   t_reg  [3];
    logic signed [DETW-1:0] det_reg;
    logic signed [CW-1:0]   c1_reg [m3i_pkg::NUM_ELEMS];
    logic signed [CW-1:0]   c2_reg [m3i_pkg::NUM_ELEMS];
    logic signed [CW-1:0]   c3_reg [m3i_pkg::NUM_ELEMS];

    // low half of the cofactor as unsigned, high half signed
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                pl_reg[j] <= a_row[j] * $signed({1'b0, cof[j][W-1:0]});
                ph_reg[j] <= a_row[j] * $signed(cof[j][CW-1:W]);
                t_reg[j]  <= (TW'(ph_reg[j]) <<< W) + TW'(pl_reg[j]);
            end
            det_reg <= DETW'(t_reg[0]) + DETW'(t_reg[1]) + DETW'(t_reg[2]);
            for (int k = 0; k < m3i_pkg::NUM_ELEMS; k++) begin
                c1_reg[k] <= cof[k];
                c2_reg[k] <= c1_reg[k];
                c3_reg[k] <= c2_reg[k];
            end
        end
    end

    assign det   = det_reg;
    assign cof_d = c3_reg;

endmodule

// File: src/m3i_div_lane.sv
// m3i_div_lane: pipelined restoring divider, one quotient bit per stage
// depends on m3i_pkg
`timescale 1ns / 1ps

module m3i_div_lane #(
    parameter int W  = 32,
    parameter int NW = 97,
    parameter int DW = 98
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [NW-1:0]       num_mag,
    input  logic [DW-1:0]       den_mag,
    input  logic                neg,
    output logic [W-1:0]        quot,
    output m3i_pkg::div_flags_t flags
);

    localparam int RW = (NW > DW + W) ? NW : DW + W;

    logic [RW-1:0] rem_reg  [W+1];
    logic [DW-1:0] den_reg  [W+1];
    logic [W-1:0]  q_reg    [W+1];
    logic          neg_reg  [W+1];
    logic          big_reg  [W+1];
    logic [RW:0]   trial    [W+1];
    logic [RW-1:0] rem_next [W+1];
    logic [W-1:0]  q_next   [W+1];

    // one trial subtraction per stage, divisor shifted by the bit weight
    always_comb begin
        trial[0]    = '0;
        rem_next[0] = '0;
        q_next[0]   = '0;
        for (int k = 1; k <= W; k++) begin
            trial[k] = {1'b0, rem_reg[k-1]} - ((RW+1)'(den_reg[k-1]) << (W - k));
            if (!trial[k][RW]) begin
                rem_next[k] = trial[k][RW-1:0];
                q_next[k]   = q_reg[k-1] | (W'(1) << (W - k));
            end else begin
                rem_next[k] = rem_reg[k-1];
                q_next[k]   = q_reg[k-1];
            end
        end
    end

    // entry stage checks for quotient overflow, then the bit stages
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= RW'(num_mag);
            den_reg[0] <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            big_reg[0] <= RW'(num_mag) >= (RW'(den_mag) << W);
            for (int k = 1; k <= W; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_next[k];
                neg_reg[k] <= neg_reg[k-1];
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign quot      = q_reg[W];
    assign flags.big = big_reg[W];
    assign flags.neg = neg_reg[W];

endmodule

// File: src/matrix3x3_inverse_core.sv
// matrix3x3_inverse_core: streaming 3x3 inverse by adjugate, Q format fixed point
// depends on m3i_pkg, m3i_cofactor, m3i_det, m3i_div_lane
`timescale 1ns / 1ps
//
//  channel  | direction | ports                         | payload
//  ---------+-----------+-------------------------------+-----------------------------
//  s_       | in        | s_valid, s_ready              | s_a11 .. s_a33, WORD_BITS each
//  m_       | out       | m_valid, m_ready              | m_b11 .. m_b33, m_singular
//
//  one matrix per cycle while m_ready takes the results; the pipeline is two cofactor
//  stages, three determinant stages, one magnitude stage, WORD_BITS + 1 divider
//  stages (one quotient bit per stage in nine parallel lanes) and the output register
//  the whole pipeline advances together; it holds while a result waits unread
//  reset (synchronous, aresetn low) clears the valid bits only

module matrix3x3_inverse_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [WORD_BITS-1:0]  s_a11,
    input  logic signed [WORD_BITS-1:0]  s_a12,
    input  logic signed [WORD_BITS-1:0]  s_a13,
    input  logic signed [WORD_BITS-1:0]  s_a21,
    input  logic signed [WORD_BITS-1:0]  s_a22,
    input  logic signed [WORD_BITS-1:0]  s_a23,
    input  logic signed [WORD_BITS-1:0]  s_a31,
    input  logic signed [WORD_BITS-1:0]  s_a32,
    input  logic signed [WORD_BITS-1:0]  s_a33,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [WORD_BITS-1:0]  m_b11,
    output logic signed [WORD_BITS-1:0]  m_b12,
    output logic signed [WORD_BITS-1:0]  m_b13,
    output logic signed [WORD_BITS-1:0]  m_b21,
    output logic signed [WORD_BITS-1:0]  m_b22,
    output logic signed [WORD_BITS-1:0]  m_b23,
    output logic signed [WORD_BITS-1:0]  m_b31,
    output logic signed [WORD_BITS-1:0]  m_b32,
    output logic signed [WORD_BITS-1:0]  m_b33,
    output logic                         m_singular
);

    localparam int W    = WORD_BITS;
    localparam int CW   = 2 * W + 1;
    localparam int DETW = 3 * W + 2;
    localparam int NW   = CW + 2 * FRAC_BITS;
    localparam int NST  = W + 8;
    localparam int LAST = NST - 1;
    localparam int NE   = m3i_pkg::NUM_ELEMS;

    logic                en;
    logic [NST-1:0]      v_reg;
    logic signed [W-1:0] a_in  [NE];
    logic signed [W-1:0] a_row [3];
    logic signed [CW-1:0] cof   [NE];
    logic signed [CW-1:0] cof_d [NE];
    logic signed [DETW-1:0] det;

    logic [NW-1:0]       num_reg  [NE];
    logic [DETW-1:0]     den_reg;
    logic                neg_reg  [NE];
    logic                sing_reg;
    logic                sing_pipe_reg [W+1];

    logic [W-1:0]        quot  [NE];
    m3i_pkg::div_flags_t flags [NE];
    logic signed [W-1:0] b_next [NE];
    logic signed [W-1:0] b_reg  [NE];
    logic                sing_out_reg;

    // global advance: hold only while a result sits unread
    assign en      = !v_reg[LAST] || m_ready;
    assign s_ready = en;
    assign m_valid = v_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], s_valid};
        end
    end

    assign a_in[0] = s_a11;
    assign a_in[1] = s_a12;
    assign a_in[2] = s_a13;
    assign a_in[3] = s_a21;
    assign a_in[4] = s_a22;
    assign a_in[5] = s_a23;
    assign a_in[6] = s_a31;
    assign a_in[7] = s_a32;
    assign a_in[8] = s_a33;

    m3i_cofactor #(.W(W)) u_cofactor (
        .aclk  (aclk),
        .en    (en),
        .a     (a_in),
        .cof   (cof),
        .a_row (a_row)
    );

    m3i_det #(.W(W)) u_det (
        .aclk  (aclk),
        .en    (en),
        .a_row (a_row),
        .cof   (cof),
        .det   (det),
        .cof_d (cof_d)
    );

    // magnitudes and signs; numerator scaled by 2^(2F); transpose at the lane input
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg  <= det[DETW-1] ? DETW'(-det) : DETW'(det);
            sing_reg <= (det == '0);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    num_reg[i*3+j] <= (cof_d[j*3+i][CW-1] ? NW'(-cof_d[j*3+i])
                                                          : NW'(cof_d[j*3+i]))
                                      << (2 * FRAC_BITS);
                    neg_reg[i*3+j] <= cof_d[j*3+i][CW-1] ^ det[DETW-1];
                end
            end
        end
    end

    for (genvar k = 0; k < NE; k++) begin : g_lane
        m3i_div_lane #(.W(W), .NW(NW), .DW(DETW)) u_lane (
            .aclk    (aclk),
            .en      (en),
            .num_mag (num_reg[k]),
            .den_mag (den_reg),
            .neg     (neg_reg[k]),
            .quot    (quot[k]),
            .flags   (flags[k])
        );
    end

    // singular flag rides alongside the divider lanes
    always_ff @(posedge aclk) begin
        if (en) begin
            sing_pipe_reg[0] <= sing_reg;
            for (int k = 1; k <= W; k++) begin
                sing_pipe_reg[k] <= sing_pipe_reg[k-1];
            end
        end
    end

    // sign, saturation and singular zeroing
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            if (sing_pipe_reg[W]) begin
                b_next[k] = '0;
            end else if (flags[k].neg) begin
                if (flags[k].big || (quot[k] > {1'b1, {(W-1){1'b0}}})) begin
                    b_next[k] = {1'b1, {(W-1){1'b0}}};
                end else begin
                    b_next[k] = $signed(-quot[k]);
                end
            end else begin
                if (flags[k].big || quot[k][W-1]) begin
                    b_next[k] = {1'b0, {(W-1){1'b1}}};
                end else begin
                    b_next[k] = $signed(quot[k]);
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg        <= b_next;
            sing_out_reg <= sing_pipe_reg[W];
        end
    end

    assign m_b11      = b_reg[0];
    assign m_b12      = b_reg[1];
    assign m_b13      = b_reg[2];
    assign m_b21      = b_reg[3];
    assign m_b22      = b_reg[4];
    assign m_b23      = b_reg[5];
    assign m_b31      = b_reg[6];
    assign m_b32      = b_reg[7];
    assign m_b33      = b_reg[8];
    assign m_singular = sing_out_reg;

endmodule
